### sv/sorted_list_engine_core_assert.svh
// assertion macros for the sorted list engine checker
`ifndef SORTED_LIST_ENGINE_CORE_ASSERT_SVH
`define SORTED_LIST_ENGINE_CORE_ASSERT_SVH

// implication checked at the same edge
`define SLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sle check failed");

// implication checked at the next edge
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sle check failed");

`endif

### sv/sle_pkg.sv
`default_nettype none

package sle_pkg;

  localparam int CAPACITY   = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int VALUE_W    = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

  // per-cell update control, broadcast along the row
  typedef struct packed {
    logic shift_in;   // insert: open a slot at the insert point
    logic shift_out;  // remove: close the slot of the first match
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/sorted_list_engine_core.sv
// channel   | valid / flow  | payload           | notes
// ----------+---------------+-------------------+------------------------------
// request   | start, busy   | request (cmd+val) | transfer when start && !busy
// result    | done          | result (st+count) | one cycle, cannot be held off
//
// one command per cycle: the row of cells compares every entry with the key
// in parallel and shifts in the same cycle, so a command's result is registered
// and shows the cycle after its transfer, with done high for that single cycle.
// busy is set by reset and cleared at the first edge without it; no clearing
// pass, the entry count alone marks which cells hold values.
// the receiver cannot stall, so nothing ever backs up into the request side.
`default_nettype none

module sorted_list_engine_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire sle_pkg::request_t request,
  output logic                   done,
  output sle_pkg::result_t       result
);

  localparam int CAP = sle_pkg::CAPACITY;

  // table state
  logic [sle_pkg::CNT_W-1:0]          count;
  logic [sle_pkg::CNT_W-1:0]          count_next;

  // row of cells
  logic signed [sle_pkg::VALUE_W-1:0] cell_value [CAP];
  logic [CAP-1:0]                     cell_lt;
  logic [CAP-1:0]                     cell_eq;
  logic [CAP-1:0]                     cell_occ;
  sle_pkg::cell_ctl_t                 ctl;

  logic                               accept;
  logic                               found;
  logic                               full;
  logic [1:0]                         status_next;

  assign accept = start && !busy;
  assign found  = |cell_eq;
  assign full   = (count == sle_pkg::CNT_W'(CAP));

  // cell i holds a value when it sits below the entry count
  for (genvar i = 0; i < CAP; i++) begin : g_row
    logic                               left_lt;
    logic signed [sle_pkg::VALUE_W-1:0] left_value;
    logic signed [sle_pkg::VALUE_W-1:0] right_value;

    assign cell_occ[i] = (count > sle_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      // head of the row: the insert point can always land here
      assign left_lt    = 1'b1;
      assign left_value = request.value;
    end else begin : g_body
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      // tail keeps its own value on a remove; it drops out of the count
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (request.value),
      .occupied    (cell_occ[i]),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  // command decode: status, count update and the cell shift controls
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = sle_pkg::ST_MISSING;
    if (accept) begin
      unique case (request.command)
        sle_pkg::CMD_INSERT: begin
          if (full) begin
            status_next = sle_pkg::ST_FULL;
          end else begin
            status_next  = sle_pkg::ST_DONE;
            ctl.shift_in = 1'b1;
            count_next   = count + 1'b1;
          end
        end
        sle_pkg::CMD_REMOVE: begin
          if (found) begin
            status_next   = sle_pkg::ST_DONE;
            ctl.shift_out = 1'b1;
            count_next    = count - 1'b1;
          end
        end
        sle_pkg::CMD_SEARCH: begin
          if (found) begin
            status_next = sle_pkg::ST_DONE;
          end
        end
        default: begin
          // unused code: no operation, reported as not found
          status_next = sle_pkg::ST_MISSING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      done  <= accept;
    end
  end

  // result payload, meaningful only while done is high
  always_ff @(posedge clk) begin
    if (accept) begin
      result.status      <= status_next;
      result.entry_count <= sle_pkg::COUNT_OUT_W'(count_next);
    end
  end

endmodule

`default_nettype wire

### sv/sle_cell.sv
`default_nettype none

module sle_cell (
  input  wire logic                              clk,
  input  wire sle_pkg::cell_ctl_t                ctl,
  input  wire logic signed [sle_pkg::VALUE_W-1:0] key,
  input  wire logic                              occupied,
  input  wire logic                              left_lt,
  input  wire logic signed [sle_pkg::VALUE_W-1:0] left_value,
  input  wire logic signed [sle_pkg::VALUE_W-1:0] right_value,
  output logic signed [sle_pkg::VALUE_W-1:0]      value,
  output logic                                   lt,
  output logic                                   eq
);

  logic signed [sle_pkg::VALUE_W-1:0] value_next;

  assign lt = occupied && (value < key);
  assign eq = occupied && (value == key);

  // cells at or past the insert/remove point move; the rest keep
  always_comb begin
    value_next = value;
    if (ctl.shift_in && !lt) begin
      value_next = left_lt ? key : left_value;
    end else if (ctl.shift_out && !lt) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

### sv/sle_checker.sv
`default_nettype none

`include "sorted_list_engine_core_assert.svh"

module sle_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire sle_pkg::request_t request,
  input wire logic              done,
  input wire sle_pkg::result_t  result
);

  // every transfer gets its result on the next cycle
  `SLE_ASSERT_NEXT(a_result_follows, start && !busy, done)

  // no result without a transfer the cycle before
  `SLE_ASSERT_NEXT(a_no_spurious_result, !(start && !busy), !done)

  // a dropped insert means the table was at capacity
  `SLE_ASSERT_NOW(a_full_count, done && result.status == sle_pkg::ST_FULL,
    result.entry_count == sle_pkg::COUNT_OUT_W'(sle_pkg::CAPACITY))

  // an insert is never reported as not found
  `SLE_ASSERT_NOW(a_insert_status, done && result.status == sle_pkg::ST_MISSING,
    $past(request.command) != sle_pkg::CMD_INSERT)

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sle_pkg::*;

  // unused command code, the block treats it as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_PER_PHASE = 150;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } stim_row_t;

  stim_row_t stim_rows[$];
  result_t   expected_results[$];

  // shadow of the table, ascending in 0 .. table_count-1
  logic signed [VALUE_W-1:0] table_values[CAPACITY];
  int                        table_count = 0;

  int  mismatch_count = 0;
  int  idle_pct = 7;
  bit  drain_bias = 1'b0;
  int  stall_cycles;

  sorted_list_engine_core DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // sorted insert, first-match remove, search; the shadow moves as the block does
  function automatic result_t predict_result(input request_t req);
    result_t res;
    int      pos;
    res.status = ST_MISSING;
    pos = 0;
    case (req.command)
      CMD_INSERT: begin
        if (table_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // new copy goes ahead of any equal values already held
          while (pos < table_count && table_values[pos] < req.value) pos++;
          for (int i = table_count; i > pos; i--) table_values[i] = table_values[i-1];
          table_values[pos] = req.value;
          table_count++;
          res.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        while (pos < table_count && table_values[pos] != req.value) pos++;
        if (pos < table_count) begin
          for (int i = pos; i + 1 < table_count; i++) table_values[i] = table_values[i+1];
          table_count--;
          res.status = ST_DONE;
        end
      end
      CMD_SEARCH: begin
        while (pos < table_count && table_values[pos] != req.value) pos++;
        if (pos < table_count) res.status = ST_DONE;
      end
      default: res.status = ST_MISSING;
    endcase
    res.entry_count = COUNT_OUT_W'(table_count);
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [31:0] value,
                                  input bit typed = 1'b0, input logic [1:0] st = ST_DONE,
                                  input int cnt = 0);
    stim_row_t row;
    row.req.command     = cmd;
    row.req.value       = value;
    row.typed           = typed;
    row.want.status     = st;
    row.want.entry_count = COUNT_OUT_W'(cnt);
    stim_rows.push_back(row);
  endfunction

  // mostly a small pool of values and values already stored, so hits and
  // duplicates are common; the rest spans the whole 32-bit range
  function automatic request_t random_request();
    request_t req;
    int       pick;
    int       ins_pct;
    pick = $urandom_range(99);
    ins_pct = drain_bias ? 25 : 60;
    if (pick < 4) req.command = CMD_UNUSED;
    else if (pick < 4 + ins_pct) req.command = CMD_INSERT;
    else if (pick < 4 + ins_pct + (96 - ins_pct) * 2 / 3) req.command = CMD_REMOVE;
    else req.command = CMD_SEARCH;
    pick = $urandom_range(99);
    if (pick < 30 && table_count > 0 && req.command != CMD_INSERT)
      req.value = table_values[$urandom_range(table_count - 1)];
    else if (pick < 65)
      req.value = 32'($urandom_range(9)) - 32'd5;
    else if (pick < 75)
      req.value = ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    else
      req.value = $urandom;
    return req;
  endfunction

  // hold start until the block takes the transfer; idle cycles carry junk
  task automatic send_request(input request_t req);
    request_t junk;
    while ($urandom_range(99) < idle_pct) begin
      junk.command = 2'($urandom_range(3));
      junk.value   = $urandom;
      start   <= 1'b0;
      request <= junk;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // result side: one strobe per transfer, compared against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result strobe with nothing outstanding (status %0d)",
                                  result.status));
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        if (result.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    result.entry_count, want.entry_count));
      end
    end
  end

  // watchdog: too long with neither a transfer nor a result ends the run
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("[sorted_list_engine_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    result_t  want;
    request_t req;
    int       phase_idle[3];
    phase_idle = '{7, 66, 0};

    // empty table: nothing to find or remove, unused code changes nothing
    add_row(CMD_SEARCH, 32'd0,         1'b1, ST_MISSING, 0);
    add_row(CMD_REMOVE, 32'h8000_0000, 1'b1, ST_MISSING, 0);
    add_row(CMD_UNUSED, 32'hffff_ffff, 1'b1, ST_MISSING, 0);
    // extremes of the value range
    add_row(CMD_INSERT, 32'h8000_0000, 1'b1, ST_DONE, 1);
    add_row(CMD_INSERT, 32'h7fff_ffff, 1'b1, ST_DONE, 2);
    add_row(CMD_SEARCH, 32'h8000_0000);
    add_row(CMD_SEARCH, 32'h7fff_ffff);
    // duplicate: remove takes one copy, the other stays findable
    add_row(CMD_INSERT, 32'h7fff_ffff);
    add_row(CMD_REMOVE, 32'h7fff_ffff);
    add_row(CMD_SEARCH, 32'h7fff_ffff);
    // fill to capacity with spread values of both signs
    for (int k = 0; k < CAPACITY - 2; k++)
      add_row(CMD_INSERT, 32'(k - 7) * 32'h0911_2233);
    // full table drops the insert
    add_row(CMD_INSERT, 32'd0, 1'b1, ST_FULL, CAPACITY);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    idle_pct = phase_idle[0];
    foreach (stim_rows[i]) begin
      send_request(stim_rows[i].req);
      want = predict_result(stim_rows[i].req);
      expected_results.push_back(stim_rows[i].typed ? stim_rows[i].want : want);
    end

    // three idling regimes, each opened by a full drain of the results
    for (int phase = 0; phase < 3; phase++) begin
      pause_until_drained();
      idle_pct = phase_idle[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // swing between filling and draining so the count sweeps empty to full
        if ($urandom_range(29) == 0) drain_bias = ~drain_bias;
        if ($urandom_range(49) == 0) pause_until_drained();
        req = random_request();
        send_request(req);
        expected_results.push_back(predict_result(req));
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("[sorted_list_engine_core] OK");
    end else begin
      $display("[sorted_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule

### sorted_list_engine_core.f
+incdir+sv
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sorted_list_engine_core.sv
sv/sle_checker.sv
dv/tb_top.sv
